>>> rtl/rus_pkg.sv
package rus_pkg;

   localparam int MAX_SIDE_DEF   = 256;
   localparam int MAX_PIXELS_DEF = 65536;

   localparam int IDX_W  = 17;   // pixel_index, merged_index, area, centres
   localparam int CFG_W  = 9;    // image_height, image_width, box fields
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 4 * IDX_W + 4 * CFG_W;

   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 1'd1;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] bottom_row;
      logic [CFG_W-1:0] top_row;
      logic [CFG_W-1:0] right_col;
      logic [CFG_W-1:0] left_col;
      logic [IDX_W-1:0] center_row;
      logic [IDX_W-1:0] center_col;
      logic [IDX_W-1:0] area;
      logic [IDX_W-1:0] merged_index;
   } rsp_data_type;

endpackage

>>> rtl/region_union_statistics_top.sv
// Merges the pixels of one proposal and reports its area, Q.8 centroid and bounding box.
// A request carries a 1-based column-major pixel index; each new included pixel gives
// one pixel result, and the request marked last gives a summary after it. A new pixel
// is split into column and row by the shared restoring divider, one bit a cycle, and
// no new request is taken until it is through; a dropped pixel skips the divider.
// A summary runs the two centroid divisions on the same divider (skipped when no pixel
// was merged), then issues its result and wipes the visited bitmap through the list of
// merged pixels. A stalled result holds the block for as long as it waits. After reset
// the bitmap is cleared, and no request is taken until it is done.
module region_union_statistics_top #(
   parameter int MAX_SIDE   = rus_pkg::MAX_SIDE_DEF,
   parameter int MAX_PIXELS = rus_pkg::MAX_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rus_pkg::REQ_DATA_W-1:0]  req_tdata,  // pixel_index
   input  logic                            req_tuser,  // include_req
   input  logic                            req_tlast,  // end_of_proposal
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // merged_index, area, center_col, center_row, left_col, right_col, top_row, bottom_row
   output logic [rus_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,  // kind
   output logic                            rsp_tlast,  // final_res
   input  logic                            csr_we,
   input  logic [rus_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rus_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int IDXW = $clog2(MAX_PIXELS);
   localparam int SIDEW = $clog2(MAX_SIDE);
   localparam int HW = SIDEW + 1;
   localparam int CNTW = IDXW + 1;
   localparam int SUMW = IDXW + SIDEW;
   localparam int NW = SUMW + 8;
   localparam int DW = (CNTW > HW) ? CNTW : HW;
   localparam int STW = $clog2(NW + 1);
   localparam int LW = 2 * HW;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_LOOK  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_PUPD  = 4'd5;
   localparam logic [3:0] S_EMITP = 4'd6;
   localparam logic [3:0] S_SUMC  = 4'd7;
   localparam logic [3:0] S_DIVC  = 4'd8;
   localparam logic [3:0] S_SUMR  = 4'd9;
   localparam logic [3:0] S_DIVR  = 4'd10;
   localparam logic [3:0] S_EMITS = 4'd11;
   localparam logic [3:0] S_WIPE  = 4'd12;

   logic [3:0] state_ff;
   logic [HW-1:0] h_ff, w_ff;
   logic [LW-1:0] lim_ff;
   logic [rus_pkg::IDX_W-1:0] idx_ff;
   logic incl_ff, last_ff;
   logic [CNTW-1:0] cnt_ff, wcnt_ff;
   logic [SUMW-1:0] csum_ff, rsum_ff;
   logic [SIDEW-1:0] minc_ff, maxc_ff, minr_ff, maxr_ff;
   logic [SIDEW-1:0] col_ff, row_ff;
   logic [rus_pkg::IDX_W-1:0] cc_ff;
   logic wipe_pend_ff;

   logic [NW-1:0] dq_ff;
   logic [DW-1:0] dr_ff, dd_ff;
   logic [STW-1:0] dstep_ff;

   logic rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   rus_pkg::rsp_data_type rsp_data_ff;
   rus_pkg::rsp_data_type sum_data;

   logic [HW-1:0] csr_clamp;
   logic [IDXW-1:0] pix;
   logic pix_ok, out_free;
   logic [DW:0] rem_sh;
   logic rem_ge;
   logic v_rdata, vw_we, vw_data;
   logic [IDXW-1:0] vw_addr;
   logic [IDXW-1:0] l_rdata;
   logic l_we;
   logic [rus_pkg::IDX_W-1:0] q_ctr;

   always_comb begin
      if (csr_wdata == '0) begin
         csr_clamp = HW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_SIDE)) begin
         csr_clamp = HW'(MAX_SIDE);
      end else begin
         csr_clamp = HW'(csr_wdata);
      end
   end

   assign pix = IDXW'(32'(idx_ff) - 32'd1);
   assign pix_ok = incl_ff && (idx_ff != '0) && (32'(idx_ff) <= 32'(lim_ff))
                   && (32'(idx_ff) <= 32'(MAX_PIXELS));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign rem_sh = {dr_ff, dq_ff[NW-1]};
   assign rem_ge = rem_sh >= {1'b0, dd_ff};
   assign q_ctr = rus_pkg::IDX_W'(dq_ff) + rus_pkg::IDX_W'(256);

   always_comb begin
      sum_data = '0;
      sum_data.area       = rus_pkg::IDX_W'(cnt_ff);
      sum_data.center_col = cc_ff;
      sum_data.center_row = (cnt_ff == '0) ? '0 : q_ctr;
      sum_data.left_col   = rus_pkg::CFG_W'(32'(minc_ff) + 32'd1);
      sum_data.right_col  = rus_pkg::CFG_W'(32'(maxc_ff) + 32'd1);
      sum_data.top_row    = rus_pkg::CFG_W'(32'(minr_ff) + 32'd1);
      sum_data.bottom_row = rus_pkg::CFG_W'(32'(maxr_ff) + 32'd1);
   end

   assign vw_we = (state_ff == S_CLEAR) || ((state_ff == S_LOOK) && !v_rdata) || wipe_pend_ff;
   assign vw_data = (state_ff == S_LOOK);
   always_comb begin
      if (state_ff == S_CLEAR) begin
         vw_addr = wcnt_ff[IDXW-1:0];
      end else if (state_ff == S_LOOK) begin
         vw_addr = pix;
      end else begin
         vw_addr = l_rdata;
      end
   end
   assign l_we = (state_ff == S_LOOK) && !v_rdata;

   rus_ram #(.WIDTH(1), .DEPTH(MAX_PIXELS)) u_visited (
      .clock (clock),
      .we    (vw_we),
      .waddr (vw_addr),
      .wdata (vw_data),
      .raddr (pix),
      .rdata (v_rdata)
   );

   rus_ram #(.WIDTH(IDXW), .DEPTH(MAX_PIXELS)) u_list (
      .clock (clock),
      .we    (l_we),
      .waddr (cnt_ff[IDXW-1:0]),
      .wdata (pix),
      .raddr (wcnt_ff[IDXW-1:0]),
      .rdata (l_rdata)
   );

   always_ff @(posedge clock) begin
      lim_ff <= LW'(h_ff) * LW'(w_ff);
      if (reset) begin
         h_ff <= HW'(MAX_SIDE);
         w_ff <= HW'(MAX_SIDE);
      end else if (csr_we) begin
         unique case (csr_index)
            rus_pkg::REG_HEIGHT: h_ff <= csr_clamp;
            rus_pkg::REG_WIDTH:  w_ff <= csr_clamp;
            default: ;
         endcase
      end
   end

   // shared restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (((state_ff == S_DIV) || (state_ff == S_DIVC) || (state_ff == S_DIVR))
          && (dstep_ff != '0)) begin
         dr_ff    <= rem_ge ? DW'(rem_sh - {1'b0, dd_ff}) : rem_sh[DW-1:0];
         dq_ff    <= {dq_ff[NW-2:0], rem_ge};
         dstep_ff <= dstep_ff - 1'b1;
      end else if (state_ff == S_LOOK) begin
         dq_ff    <= {pix, {(NW-IDXW){1'b0}}};
         dr_ff    <= '0;
         dd_ff    <= DW'(h_ff);
         dstep_ff <= STW'(IDXW);
      end else if ((state_ff == S_SUMC) || (state_ff == S_SUMR)) begin
         dq_ff    <= (state_ff == S_SUMC) ? {csum_ff, 8'd0} : {rsum_ff, 8'd0};
         dr_ff    <= '0;
         dd_ff    <= DW'(cnt_ff);
         dstep_ff <= STW'(NW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wcnt_ff      <= '0;
         wipe_pend_ff <= 1'b0;
         cnt_ff       <= '0;
         csum_ff      <= '0;
         rsum_ff      <= '0;
         minc_ff      <= SIDEW'(MAX_SIDE - 1);
         maxc_ff      <= '0;
         minr_ff      <= SIDEW'(MAX_SIDE - 1);
         maxr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (((state_ff == S_EMITP) || (state_ff == S_EMITS)) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         wipe_pend_ff <= (state_ff == S_WIPE) && (wcnt_ff < cnt_ff);
         unique case (state_ff)
            S_CLEAR: begin
               if (32'(wcnt_ff) == 32'(MAX_PIXELS - 1)) begin
                  wcnt_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  wcnt_ff <= wcnt_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  idx_ff   <= req_tdata[rus_pkg::IDX_W-1:0];
                  incl_ff  <= req_tuser;
                  last_ff  <= req_tlast;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: state_ff <= pix_ok ? S_LOOK : (last_ff ? S_SUMC : S_IDLE);
            S_LOOK:  state_ff <= !v_rdata ? S_DIV : (last_ff ? S_SUMC : S_IDLE);
            S_DIV: begin
               if (dstep_ff == '0) begin
                  col_ff   <= dq_ff[SIDEW-1:0];
                  row_ff   <= dr_ff[SIDEW-1:0];
                  state_ff <= S_PUPD;
               end
            end
            S_PUPD: begin
               cnt_ff  <= cnt_ff + 1'b1;
               csum_ff <= csum_ff + SUMW'(col_ff);
               rsum_ff <= rsum_ff + SUMW'(row_ff);
               if (col_ff < minc_ff) minc_ff <= col_ff;
               if (col_ff > maxc_ff) maxc_ff <= col_ff;
               if (row_ff < minr_ff) minr_ff <= row_ff;
               if (row_ff > maxr_ff) maxr_ff <= row_ff;
               state_ff <= S_EMITP;
            end
            S_EMITP: begin
               if (out_free) begin
                  rsp_user_ff  <= rus_pkg::KIND_PIXEL;
                  rsp_last_ff  <= !last_ff;
                  rsp_data_ff  <= rus_pkg::rsp_data_type'(rus_pkg::RSP_DATA_W'(idx_ff));
                  state_ff <= last_ff ? S_SUMC : S_IDLE;
               end
            end
            S_SUMC: begin
               cc_ff    <= '0;
               state_ff <= (cnt_ff == '0) ? S_EMITS : S_DIVC;
            end
            S_DIVC: begin
               if (dstep_ff == '0) begin
                  cc_ff    <= q_ctr;
                  state_ff <= S_SUMR;
               end
            end
            S_SUMR:  state_ff <= S_DIVR;
            S_DIVR:  if (dstep_ff == '0) state_ff <= S_EMITS;
            S_EMITS: begin
               if (out_free) begin
                  rsp_user_ff  <= rus_pkg::KIND_SUMMARY;
                  rsp_last_ff  <= 1'b1;
                  rsp_data_ff  <= sum_data;
                  wcnt_ff  <= '0;
                  state_ff <= S_WIPE;
               end
            end
            S_WIPE: begin
               // walk the merged list, dropping each bitmap mark in the cycle after its read
               if (wcnt_ff < cnt_ff) begin
                  wcnt_ff <= wcnt_ff + 1'b1;
               end else if (!wipe_pend_ff) begin
                  wcnt_ff  <= '0;
                  cnt_ff   <= '0;
                  csum_ff  <= '0;
                  rsum_ff  <= '0;
                  minc_ff  <= SIDEW'(w_ff - 1'b1);
                  maxc_ff  <= '0;
                  minr_ff  <= SIDEW'(h_ff - 1'b1);
                  maxr_ff  <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_CHECK)
      else $error("accepted request did not reach range check");

   a_pixel_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rus_pkg::KIND_PIXEL |-> rsp_data_ff.merged_index != '0)
      else $error("pixel result with zero index");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(MAX_PIXELS))
      else $error("merged count beyond bitmap size");

   a_empty_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rus_pkg::KIND_SUMMARY && rsp_data_ff.area == '0
      |-> rsp_data_ff.center_col == '0 && rsp_data_ff.center_row == '0)
      else $error("empty proposal with non-zero centroid");

   a_wipe_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WIPE && $past(state_ff) == S_WIPE |-> wcnt_ff <= cnt_ff)
      else $error("bitmap wipe ran past merged list");

endmodule

>>> rtl/rus_ram.sv
module rus_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> tb/tb_region_union_statistics_top.sv
`timescale 1ns / 1ps

class proposal_scoreboard;
   bit visited [int unsigned];
   int unsigned height, width;
   int unsigned count;
   longint unsigned col_total, row_total;
   int unsigned lo_col, hi_col, lo_row, hi_row;
   rus_pkg::rsp_data_type expected_data [$];
   bit expected_kind [$];
   bit expected_last [$];
   int errors;

   function new();
      height = 256;
      width = 256;
      errors = 0;
      clear_proposal();
   endfunction

   function int unsigned clamp_side(int unsigned v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function void set_register(bit idx, int unsigned value);
      if (idx == rus_pkg::REG_HEIGHT) height = clamp_side(value & 'h1FF);
      else width = clamp_side(value & 'h1FF);
   endfunction

   function void clear_proposal();
      visited.delete();
      count = 0;
      col_total = 0;
      row_total = 0;
      lo_col = width - 1;
      hi_col = 0;
      lo_row = height - 1;
      hi_row = 0;
   endfunction

   function int pending();
      return expected_data.size();
   endfunction

   function void note_expected(rus_pkg::rsp_data_type d, bit kind, bit fin);
      expected_data.insert(expected_data.size(), d);
      expected_kind.insert(expected_kind.size(), kind);
      expected_last.insert(expected_last.size(), fin);
   endfunction

   // predict the results of one accepted request
   function void note_request(int unsigned pix, bit incl, bit last);
      rus_pkg::rsp_data_type d;
      int unsigned p, c, r;
      if (incl && pix != 0 && pix <= height * width && pix <= 65536 && !visited.exists(pix)) begin
         p = pix - 1;
         c = p / height;
         r = p % height;
         visited[pix] = 1;
         count++;
         col_total += c;
         row_total += r;
         if (c < lo_col) lo_col = c;
         if (c > hi_col) hi_col = c;
         if (r < lo_row) lo_row = r;
         if (r > hi_row) hi_row = r;
         d = '0;
         d.merged_index = rus_pkg::IDX_W'(pix);
         note_expected(d, rus_pkg::KIND_PIXEL, !last);
      end
      if (last) begin
         d = '0;
         d.area = rus_pkg::IDX_W'(count);
         if (count != 0) begin
            d.center_col = rus_pkg::IDX_W'((col_total * 256) / count + 256);
            d.center_row = rus_pkg::IDX_W'((row_total * 256) / count + 256);
         end
         d.left_col = rus_pkg::CFG_W'(lo_col + 1);
         d.right_col = rus_pkg::CFG_W'(hi_col + 1);
         d.top_row = rus_pkg::CFG_W'(lo_row + 1);
         d.bottom_row = rus_pkg::CFG_W'(hi_row + 1);
         note_expected(d, rus_pkg::KIND_SUMMARY, 1'b1);
         clear_proposal();
      end
   endfunction

   function void check_result(rus_pkg::rsp_data_type got, bit kind, bit fin);
      rus_pkg::rsp_data_type e;
      bit ek, el;
      if (expected_data.size() == 0) begin
         $error("unexpected result %h", got);
         errors++;
         return;
      end
      e = expected_data.pop_front();
      ek = expected_kind.pop_front();
      el = expected_last.pop_front();
      if (kind !== ek) begin
         $error("kind expected %0d actual %0d", ek, kind); errors++;
      end
      if (fin !== el) begin
         $error("final_res expected %0d actual %0d", el, fin); errors++;
      end
      if (got.merged_index !== e.merged_index) begin
         $error("merged_index expected %0d actual %0d", e.merged_index, got.merged_index);
         errors++;
      end
      if (got.area !== e.area) begin
         $error("area expected %0d actual %0d", e.area, got.area); errors++;
      end
      if (got.center_col !== e.center_col) begin
         $error("center_col expected %0d actual %0d", e.center_col, got.center_col);
         errors++;
      end
      if (got.center_row !== e.center_row) begin
         $error("center_row expected %0d actual %0d", e.center_row, got.center_row);
         errors++;
      end
      if (got.left_col !== e.left_col) begin
         $error("left_col expected %0d actual %0d", e.left_col, got.left_col); errors++;
      end
      if (got.right_col !== e.right_col) begin
         $error("right_col expected %0d actual %0d", e.right_col, got.right_col); errors++;
      end
      if (got.top_row !== e.top_row) begin
         $error("top_row expected %0d actual %0d", e.top_row, got.top_row); errors++;
      end
      if (got.bottom_row !== e.bottom_row) begin
         $error("bottom_row expected %0d actual %0d", e.bottom_row, got.bottom_row);
         errors++;
      end
   endfunction
endclass

module tb_region_union_statistics_top;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [rus_pkg::REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser, rsp_tlast;
   logic [rus_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we;
   logic [rus_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rus_pkg::CFG_W-1:0] csr_wdata;

   int send_idle_pct, recv_idle_pct;
   proposal_scoreboard board;

   region_union_statistics_top DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("region_union_statistics_top: mismatch");
      $finish;
   end

   // stall the result side at random
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rus_pkg::rsp_data_type'(rsp_tdata), rsp_tuser, rsp_tlast);
   end

   task automatic send_request(int unsigned pix, bit incl, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rus_pkg::REQ_DATA_W'(pix);
      req_tuser <= incl;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(pix, incl, last);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      // the bitmap wipe after a summary may still run once its result has gone
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_register(logic [rus_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rus_pkg::CFG_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_register(idx, value);
      @(posedge clock);
   endtask

   // random index biased into the image, with a little noise outside it
   function automatic int unsigned pick_index();
      int unsigned lim;
      lim = board.height * board.width;
      case ($urandom_range(19))
         0: return 0;
         1: return $urandom_range(131071);
         2: return lim;
         default: return $urandom_range(lim, 1);
      endcase
   endfunction

   task automatic random_proposals(int items);
      int sent, len, k;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(12, 1);
         if ($urandom_range(9) == 0) len = $urandom_range(60, 20);
         for (k = 0; k < len; k++) begin
            send_request(($urandom_range(3) == 0 && k > 0) ? board.height : pick_index(),
                         $urandom_range(9) != 0, k == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned h_set [4] = '{1, 256, 17, 300};
      int unsigned w_set [4] = '{256, 1, 23, 0};
      int ph;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0; req_tlast = 1'b0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      send_idle_pct = 22; recv_idle_pct = 46;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, repeats, excluded, out of range, empty
      send_request(1, 1, 0);
      send_request(1, 1, 0);
      send_request(65536, 1, 0);
      send_request(256, 1, 0);
      send_request(65281, 1, 0);
      send_request(0, 1, 0);
      send_request(131071, 1, 0);
      send_request(65537, 1, 0);
      send_request(300, 0, 0);
      send_request(777, 1, 1);
      send_request(5, 0, 1);
      send_request(0, 1, 1);
      send_request(65536, 1, 1);
      send_request(1, 1, 1);
      send_request(2, 1, 0);
      send_request(2, 1, 1);
      // hold the sender until all results are back
      drain_results();

      for (ph = 0; ph < 4; ph++) begin
         write_register(rus_pkg::REG_HEIGHT, h_set[ph]);
         write_register(rus_pkg::REG_WIDTH, w_set[ph]);
         if (ph == 2) begin
            send_request(1, 1, 0);
            send_request(board.height * board.width, 1, 0);
            send_request(board.height * board.width + 1, 1, 1);
            send_idle_pct = 46; recv_idle_pct = 22;
         end
         if (ph == 3) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         random_proposals(350);
         drain_results();
      end

      if (board.errors == 0 && board.pending() == 0)
         $display("region_union_statistics_top: match");
      else
         $display("region_union_statistics_top: mismatch");
      $finish;
   end
endmodule
